// ===== hw/rtl/mi4_pkg.sv =====
// Shared types and helpers for the 4x4 matrix inverse block.
// Holds the sequencer state type and the cofactor term address map.
// No dependencies.
package mi4_pkg;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_COF,
      ST_DET,
      ST_CHECK,
      ST_SING,
      ST_READ,
      ST_LAUNCH,
      ST_WAIT
   } state_type;

   localparam logic [3:0] LAST_ELEM      = 4'd15;
   localparam logic [2:0] LAST_TERM      = 3'd5;
   localparam logic [2:0] COF_LAST_PHASE = 3'd6;
   localparam logic [2:0] DET_LAST_PHASE = 3'd2;
   localparam logic [1:0] LAST_DET_ROW   = 2'd3;

   // Matrix address of factor pos of term t of the adjugate entry idx.
   // Terms follow the six-term 3x3 expansion; rows/cols skip c/r.
   function automatic logic [3:0] mi4_cof_addr(input logic [3:0] idx,
                                                input logic [2:0] term,
                                                input logic [1:0] pos);
      logic [1:0] r;
      logic [1:0] c;
      logic [1:0] ri;
      logic [1:0] ci;
      logic [1:0] row;
      logic [1:0] col;
      r = idx[3:2];
      c = idx[1:0];
      case (term[2:1])
         2'd0: ri = pos;
         2'd1: ri = (pos == 2'd0) ? 2'd1 : ((pos == 2'd1) ? 2'd0 : 2'd2);
         default: ri = (pos == 2'd0) ? 2'd2 : ((pos == 2'd1) ? 2'd0 : 2'd1);
      endcase
      if (term[0]) begin
         ci = (pos == 2'd1) ? 2'd2 : ((pos == 2'd2) ? 2'd1 : 2'd0);
      end else begin
         ci = pos;
      end
      row = (ri < c) ? ri : ri + 2'd1;
      col = (ci < r) ? ci : ci + 2'd1;
      return {row, col};
   endfunction

   function automatic logic mi4_term_neg(input logic [2:0] term);
      return (term == 3'd1) || (term == 3'd2) || (term == 3'd5);
   endfunction

endpackage

// ===== hw/rtl/mi4_divider.sv =====
// Bit-serial rounding divider: magnitude quotient with saturation and sign.
// One quotient bit per cycle. Depends on nothing outside this file.
module mi4_divider #(
   parameter int EW = 16,
   parameter int NW = 64,
   parameter int DW = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic [NW-1:0]        num_mag,
   input  logic [DW-1:0]        den_mag,
   input  logic                 neg,
   output logic                 done,
   output logic signed [EW-1:0] value
);
   localparam int QW  = EW - 1;
   localparam int RW  = ((NW > DW) ? NW : DW) + QW + 1;
   localparam int CTW = $clog2(QW);

   logic [RW-1:0]  rem_ff, dsh_ff, start_rem;
   logic [QW-1:0]  q_ff, q_in;
   logic [CTW-1:0] cnt_ff;
   logic           sat_ff, neg_ff, run_ff, done_ff, ge;
   logic signed [EW-1:0] value_ff, value_in;

   // numerator pre-biased by half the divisor for round-half-away
   assign start_rem = RW'(num_mag) + RW'(den_mag >> 1);
   assign ge        = rem_ff >= dsh_ff;
   assign q_in      = {q_ff[QW-2:0], ge};

   always_comb begin
      if (sat_ff) begin
         value_in = neg_ff ? {1'b1, {QW{1'b0}}} : {1'b0, {QW{1'b1}}};
      end else if (neg_ff) begin
         value_in = -$signed({1'b0, q_in});
      end else begin
         value_in = $signed({1'b0, q_in});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff <= 1'b1;
            cnt_ff <= CTW'(QW - 1);
         end else if (run_ff) begin
            if (cnt_ff == '0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rem_ff <= start_rem;
         dsh_ff <= RW'(den_mag) << (QW - 1);
         sat_ff <= start_rem >= (RW'(den_mag) << QW);
         neg_ff <= neg;
         q_ff   <= '0;
      end else if (run_ff) begin
         if (ge) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         dsh_ff <= dsh_ff >> 1;
         q_ff   <= q_in;
         if (cnt_ff == '0) begin
            value_ff <= value_in;
         end
      end
   end

   assign done  = done_ff;
   assign value = value_ff;

endmodule

// ===== hw/rtl/matrix_inverse_4x4.sv =====
// 4x4 matrix inverse by adjugate: 16 element beats in, 16 inverse beats (or one singular) out.
// After the sixteenth beat it computes the sixteen cofactors term by term, then the determinant,
// then a zero check, then one rounded quotient per element, each through the serial divider.
// A singular matrix gives its one result after the zero check. Busy is high until the last result,
// so the next matrix is not accepted until then; no stall input.
// Synchronous active-high reset clears control state; memories are not cleared.
module matrix_inverse_4x4 import mi4_pkg::*; #(
   parameter int ELEMENT_WIDTH = 16,
   parameter int FRACTION_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic signed [ELEMENT_WIDTH-1:0] req_element_value,
   output logic                            rsp_valid,
   output logic [3:0]                      rsp_element_index,
   output logic signed [ELEMENT_WIDTH-1:0] rsp_inverse_value,
   output logic                            rsp_singular,
   output logic                            rsp_last_result
);
   localparam int EW = ELEMENT_WIDTH;
   localparam int F  = FRACTION_BITS;
   localparam int CW = 3 * EW + 4;
   localparam int PW = CW + EW;
   localparam int SW = PW + 2;
   localparam int DW = 4 * EW;
   localparam int NW = CW + F;

   state_type state_ff, state_in;

   logic [3:0] load_count_ff, cof_idx_ff, out_idx_ff;
   logic [2:0] term_ff, phase_ff;
   logic [1:0] det_k_ff;
   logic signed [DW-1:0] det_ff, det_next;

   logic signed [EW-1:0]   mat_mem [16];
   logic signed [CW-1:0]   cof_mem [16];
   logic signed [EW-1:0]   mat_rdata_ff;
   logic signed [CW-1:0]   cof_rdata_ff;
   logic [3:0]             mat_raddr, cof_raddr;
   logic                   mat_we, cof_we, accept;
   logic signed [CW-1:0]   cof_wdata;

   logic signed [EW-1:0]   ra_ff, rb_ff, rc_ff;
   logic signed [2*EW-1:0] p1_ff;
   logic signed [3*EW-1:0] p2_ff;
   logic signed [CW-1:0]   acc_ff, acc_next;
   logic signed [PW-1:0]   prod_ff;
   logic signed [SW-1:0]   sum_ff, sum_next;

   logic [CW-1:0]          cof_abs;
   logic [DW-1:0]          det_abs;
   logic                   div_go, div_done;
   logic signed [EW-1:0]   div_value;

   assign accept   = start && !busy;
   assign mat_we   = accept;
   assign cof_we   = (state_ff == ST_COF) && (phase_ff == COF_LAST_PHASE)
                     && (term_ff == LAST_TERM);
   assign acc_next = mi4_term_neg(term_ff) ? acc_ff - CW'(p2_ff) : acc_ff + CW'(p2_ff);
   // odd r+c flips the minor's sign
   assign cof_wdata = (cof_idx_ff[2] ^ cof_idx_ff[0]) ? -acc_next : acc_next;
   assign sum_next = sum_ff + SW'(prod_ff);
   assign det_next = DW'(sum_next >>> F);

   always_comb begin
      mat_raddr = mi4_cof_addr(cof_idx_ff, term_ff, phase_ff[1:0]);
      cof_raddr = out_idx_ff;
      if (state_ff == ST_DET) begin
         mat_raddr = {2'b00, det_k_ff};
         cof_raddr = {det_k_ff, 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (mat_we) begin
         mat_mem[load_count_ff] <= req_element_value;
      end
      mat_rdata_ff <= mat_mem[mat_raddr];
   end

   always_ff @(posedge clock) begin
      if (cof_we) begin
         cof_mem[cof_idx_ff] <= cof_wdata;
      end
      cof_rdata_ff <= cof_mem[cof_raddr];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept && (load_count_ff == LAST_ELEM)) state_in = ST_COF;
         end
         ST_COF: begin
            if (cof_we && (cof_idx_ff == LAST_ELEM)) state_in = ST_DET;
         end
         ST_DET: begin
            if ((phase_ff == DET_LAST_PHASE) && (det_k_ff == LAST_DET_ROW)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: state_in = (det_ff == '0) ? ST_SING : ST_READ;
         ST_SING: state_in = ST_LOAD;
         ST_READ: state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = ST_WAIT;
         ST_WAIT: begin
            if (div_done) state_in = (out_idx_ff == LAST_ELEM) ? ST_LOAD : ST_READ;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      busy              = state_ff != ST_LOAD;
      div_go            = state_ff == ST_LAUNCH;
      rsp_valid         = (state_ff == ST_SING) || ((state_ff == ST_WAIT) && div_done);
      rsp_singular      = state_ff == ST_SING;
      rsp_element_index = rsp_singular ? 4'd0 : out_idx_ff;
      rsp_inverse_value = rsp_singular ? '0 : div_value;
      rsp_last_result   = rsp_singular || (out_idx_ff == LAST_ELEM);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         load_count_ff <= '0;
         cof_idx_ff    <= '0;
         term_ff       <= '0;
         phase_ff      <= '0;
         det_k_ff      <= '0;
         out_idx_ff    <= '0;
         det_ff        <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_LOAD: begin
               if (accept) begin
                  load_count_ff <= load_count_ff + 1'b1;
                  cof_idx_ff    <= '0;
                  term_ff       <= '0;
                  phase_ff      <= '0;
                  det_k_ff      <= '0;
                  out_idx_ff    <= '0;
               end
            end
            ST_COF: begin
               if (phase_ff == COF_LAST_PHASE) begin
                  phase_ff <= '0;
                  if (term_ff == LAST_TERM) begin
                     term_ff    <= '0;
                     cof_idx_ff <= cof_idx_ff + 1'b1;
                  end else begin
                     term_ff <= term_ff + 1'b1;
                  end
               end else begin
                  phase_ff <= phase_ff + 1'b1;
               end
            end
            ST_DET: begin
               if (phase_ff == DET_LAST_PHASE) begin
                  phase_ff <= '0;
                  det_k_ff <= det_k_ff + 1'b1;
                  if (det_k_ff == LAST_DET_ROW) det_ff <= det_next;
               end else begin
                  phase_ff <= phase_ff + 1'b1;
               end
            end
            ST_WAIT: begin
               if (div_done) out_idx_ff <= out_idx_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   // datapath, cofactor phases: 1..3 catch factors, 4..5 multiply, 6 accumulates
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_LOAD: begin
            acc_ff <= '0;
            sum_ff <= '0;
         end
         ST_COF: begin
            case (phase_ff)
               3'd1: ra_ff <= mat_rdata_ff;
               3'd2: rb_ff <= mat_rdata_ff;
               3'd3: rc_ff <= mat_rdata_ff;
               3'd4: p1_ff <= ra_ff * rb_ff;
               3'd5: p2_ff <= p1_ff * rc_ff;
               3'd6: acc_ff <= (term_ff == LAST_TERM) ? '0 : acc_next;
               default: ;
            endcase
         end
         ST_DET: begin
            if (phase_ff == 3'd1) prod_ff <= mat_rdata_ff * cof_rdata_ff;
            if (phase_ff == DET_LAST_PHASE) sum_ff <= sum_next;
         end
         default: ;
      endcase
   end

   assign cof_abs = cof_rdata_ff[CW-1] ? $unsigned(-cof_rdata_ff) : $unsigned(cof_rdata_ff);
   assign det_abs = det_ff[DW-1] ? $unsigned(-det_ff) : $unsigned(det_ff);

   mi4_divider #(
      .EW(EW),
      .NW(NW),
      .DW(DW)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .go      (div_go),
      .num_mag ({cof_abs, {F{1'b0}}}),
      .den_mag (det_abs),
      .neg     (cof_rdata_ff[CW-1] ^ det_ff[DW-1]),
      .done    (div_done),
      .value   (div_value)
   );

   a_rsp_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result beat while idle");

   a_singular_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular) |-> (rsp_last_result && (rsp_element_index == 4'd0)))
      else $error("singular beat malformed");

   a_load_to_cof: assert property (@(posedge clock) disable iff (reset)
      (accept && (load_count_ff == LAST_ELEM)) |=> (state_ff == ST_COF && busy))
      else $error("sixteenth beat did not start compute");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_WAIT)) else $error("divider done out of sequence");

endmodule

// ===== dv/matrix_inverse_4x4_checker.sv =====
// Scoreboard for the 4x4 matrix inverse: snoops the load and result channels,
// predicts inverse elements with exact integer math, and counts mismatches.
// Uses nothing from mi4_pkg.
`timescale 1ns / 100ps
module matrix_inverse_4x4_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [15:0] req_element_value,
   input  logic               rsp_valid,
   input  logic [3:0]         rsp_element_index,
   input  logic signed [15:0] rsp_inverse_value,
   input  logic               rsp_singular,
   input  logic               rsp_last_result,
   output int                 mismatches,
   output int                 outstanding
);

   localparam int FRAC = 12;

   typedef struct packed {
      logic [3:0]         index;
      logic signed [15:0] value;
      logic               singular;
      logic               last;
   } inv_beat_type;

   inv_beat_type       inverse_queue[$];
   logic signed [15:0] matrix_elems[16];
   int                 loaded;

   // signed 3x3 minor with row c and column r removed (adjugate is transposed)
   function automatic longint adjugate_term(int r, int c);
      int     rows[3];
      int     cols[3];
      int     n;
      int     m;
      longint a[3][3];
      longint d;
      n = 0;
      m = 0;
      for (int i = 0; i < 4; i++) begin
         if (i != c) begin
            rows[n] = i;
            n++;
         end
         if (i != r) begin
            cols[m] = i;
            m++;
         end
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            a[i][j] = longint'(matrix_elems[rows[i] * 4 + cols[j]]);
      d = a[0][0] * a[1][1] * a[2][2] - a[0][0] * a[1][2] * a[2][1]
        - a[1][0] * a[0][1] * a[2][2] + a[1][0] * a[0][2] * a[2][1]
        + a[2][0] * a[0][1] * a[1][2] - a[2][0] * a[0][2] * a[1][1];
      if ((r + c) % 2 == 1) d = -d;
      return d;
   endfunction

   // round half away from zero, then clamp to Q4.12
   function automatic logic signed [15:0] saturating_quotient(longint cof, longint det);
      longint          num;
      bit              neg;
      longint unsigned an;
      longint unsigned ad;
      longint unsigned mag;
      num = cof * (longint'(1) <<< FRAC);
      neg = (num < 0) != (det < 0);
      an  = (num < 0) ? longint'(-num) : num;
      ad  = (det < 0) ? longint'(-det) : det;
      if (ad == 0) return 16'sd0;
      mag = (an + ad / 2) / ad;
      if (neg) return (mag >= 32768) ? -16'sd32768 : 16'(-longint'(mag));
      return (mag >= 32768) ? 16'sd32767 : 16'(mag);
   endfunction

   task automatic predict_inverse();
      longint       cof[16];
      longint       p;
      longint       hi;
      longint       hi_sum;
      longint       lo_sum;
      longint       det;
      inv_beat_type e;
      hi_sum = 0;
      lo_sum = 0;
      for (int k = 0; k < 16; k++) cof[k] = adjugate_term(k / 4, k % 4);
      // split keeps the element-times-cofactor products from overflowing the sum
      for (int k = 0; k < 4; k++) begin
         p = longint'(matrix_elems[k]) * cof[k * 4];
         hi = p >>> FRAC;
         hi_sum += hi;
         lo_sum += p - (hi <<< FRAC);
      end
      det = hi_sum + (lo_sum >>> FRAC);
      if (det == 0) begin
         e = '{index: 4'd0, value: 16'sd0, singular: 1'b1, last: 1'b1};
         inverse_queue.push_back(e);
      end else begin
         for (int k = 0; k < 16; k++) begin
            e = '{index: 4'(k), value: saturating_quotient(cof[k], det),
                  singular: 1'b0, last: (k == 15)};
            inverse_queue.push_back(e);
         end
      end
   endtask

   task automatic report(string what);
      $display("%0t mismatch: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      inv_beat_type e;
      if (reset) begin
         mismatches = 0;
         loaded = 0;
         inverse_queue.delete();
      end else begin
         if (start && !busy) begin
            matrix_elems[loaded] = req_element_value;
            loaded++;
            if (loaded == 16) begin
               loaded = 0;
               predict_inverse();
            end
         end
         if (rsp_valid) begin
            if (inverse_queue.size() == 0) begin
               report("result beat with nothing expected");
            end else begin
               e = inverse_queue.pop_front();
               if (rsp_element_index !== e.index)
                  report($sformatf("index %0d, want %0d", rsp_element_index, e.index));
               if (rsp_inverse_value !== e.value)
                  report($sformatf("value %0d at index %0d, want %0d",
                                   rsp_inverse_value, e.index, e.value));
               if (rsp_singular !== e.singular)
                  report($sformatf("singular %b, want %b", rsp_singular, e.singular));
               if (rsp_last_result !== e.last)
                  report($sformatf("last %b at index %0d, want %b",
                                   rsp_last_result, e.index, e.last));
            end
         end
      end
      outstanding = inverse_queue.size();
   end

endmodule

// ===== dv/matrix_inverse_4x4_tb.sv =====
// Top of the 4x4 matrix inverse testbench: clock, reset, matrix stimulus and verdict.
// Depends on mi4_pkg, matrix_inverse_4x4 and matrix_inverse_4x4_checker.
`timescale 1ns / 100ps
module matrix_inverse_4x4_tb;

   localparam int IDLE_LIMIT = 20000;
   localparam int MATRICES   = 18;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [15:0] req_element_value;
   logic               rsp_valid;
   logic [3:0]         rsp_element_index;
   logic signed [15:0] rsp_inverse_value;
   logic               rsp_singular;
   logic               rsp_last_result;
   int                 mismatches;
   int                 outstanding;
   int                 idle_cycles;
   bit                 gaps_on;
   logic signed [15:0] mat[16];

   matrix_inverse_4x4 dut (.*);

   matrix_inverse_4x4_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("matrix_inverse_4x4_tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_beat(logic signed [15:0] v);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      start <= 1'b1;
      req_element_value <= v;
      do @(posedge clock); while (busy);
   endtask

   task automatic send_matrix();
      for (int i = 0; i < 16; i++) send_beat(mat[i]);
   endtask

   function automatic logic signed [15:0] small_noise(int span);
      return 16'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   task automatic build_random(int kind);
      for (int i = 0; i < 16; i++) begin
         case (kind)
            0: mat[i] = 16'($urandom);
            1: mat[i] = ((i % 5 == 0) ? 16'sd4096 : 16'sd0) + small_noise(600);
            2: mat[i] = 16'($urandom);
            3: mat[i] = small_noise(3);
            4: mat[i] = (i % 5 == 0) ? small_noise(40) : 16'sd0;
            default: mat[i] = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
         endcase
      end
      // duplicate row: exactly singular
      if (kind == 2)
         for (int j = 0; j < 4; j++) mat[12 + j] = mat[j];
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_element_value = '0;
      gaps_on = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // identity, then all-extreme matrix
      for (int i = 0; i < 16; i++) mat[i] = (i % 5 == 0) ? 16'sd4096 : 16'sd0;
      send_matrix();
      for (int i = 0; i < 16; i++) mat[i] = (i % 5 == 0) ? -16'sd32768 : 16'sd32767;
      send_matrix();

      gaps_on = 1'b1;
      for (int n = 0; n < MATRICES; n++) begin
         if (n == MATRICES - 4) gaps_on = 1'b0;
         build_random(n < 6 ? n : $urandom_range(0, 5));
         send_matrix();
         if (n == 3) begin
            start <= 1'b0;
            // let the scoreboard queue the last matrix before polling outstanding
            @(posedge clock);
            while (outstanding != 0) @(posedge clock);
         end
      end
      start <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("matrix_inverse_4x4_tb: PASS");
      end else begin
         $display("matrix_inverse_4x4_tb: FAIL");
      end
      $finish;
   end

endmodule
